// ===== sv/lcoc_pkg.sv =====
// shared types, constants and modular arithmetic helpers for the collision offset check
package lcoc_pkg;

	localparam int QUEUE_DEPTH = 2;

	typedef struct packed {
		logic [31:0] prime_p;
		logic [31:0] prime_q;
		logic [63:0] p_root;
		logic [63:0] q_root;
		logic [31:0] lattice_limit;
		logic [7:0]  poly_index;
	} lcoc_item_t;

	typedef struct packed {
		logic        hit;
		logic [63:0] offset;
		logic [31:0] out_p;
		logic [31:0] out_q;
		logic [63:0] out_root;
		logic [7:0]  out_poly;
	} lcoc_result_t;

	// classified item as handed from front to back
	typedef struct packed {
		lcoc_item_t  item;
		logic [63:0] modulus;
		logic [63:0] p_sq;
		logic        degen;
	} lcoc_job_t;

	// a, b < m
	function automatic logic [63:0] add_mod(input logic [63:0] a, input logic [63:0] b,
		input logic [63:0] m);
		logic [63:0] room;
		room = m - b;
		return (a >= room) ? (a - room) : (a + b);
	endfunction

	// a, b < m
	function automatic logic [63:0] sub_mod(input logic [63:0] a, input logic [63:0] b,
		input logic [63:0] m);
		return (a >= b) ? (a - b) : (a + (m - b));
	endfunction

endpackage

// ===== sv/lcoc_if.sv =====
// valid/ready channel interfaces for input items and results
interface lcoc_in_if import lcoc_pkg::*; ();
	logic       valid;
	logic       ready;
	lcoc_item_t data;
	modport source(output valid, output data, input ready);
	modport sink(input valid, input data, output ready);
endinterface

interface lcoc_out_if import lcoc_pkg::*; ();
	logic         valid;
	logic         ready;
	lcoc_result_t data;
	modport source(output valid, output data, input ready);
	modport sink(input valid, input data, output ready);
endinterface

// ===== sv/lcoc_front.sv =====
// front end: takes input transactions, squares the primes and flags degenerate moduli
module lcoc_front import lcoc_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	lcoc_in_if.sink   item,
	output lcoc_job_t job,
	output logic      job_valid,
	input  logic      job_ready
);
	lcoc_item_t item_s1;
	logic       valid_s1;

	assign item.ready = !valid_s1 || job_ready;
	assign job_valid  = valid_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (item.ready) begin
			valid_s1 <= item.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (item.ready && item.valid) begin
			item_s1 <= item.data;
		end
	end

	// products land in the queue registers
	always_comb begin
		job.item    = item_s1;
		job.modulus = 64'(item_s1.prime_q) * 64'(item_s1.prime_q);
		job.p_sq    = 64'(item_s1.prime_p) * 64'(item_s1.prime_p);
		job.degen   = (item_s1.prime_q < 32'd2);
	end
endmodule

// ===== sv/lcoc_fifo.sv =====
// short job queue between front and back
module lcoc_fifo import lcoc_pkg::*; #(
	parameter int DEPTH = QUEUE_DEPTH
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      push,
	input  lcoc_job_t push_data,
	output logic      full,
	input  logic      pop,
	output lcoc_job_t pop_data,
	output logic      empty
);
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	lcoc_job_t       mem_q [DEPTH];
	logic [AW-1:0]   wr_q, rd_q;
	logic [CW-1:0]   count_q;

	assign full     = (count_q == CW'(DEPTH));
	assign empty    = (count_q == '0);
	assign pop_data = mem_q[rd_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q    <= '0;
			rd_q    <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				wr_q <= (wr_q == AW'(DEPTH - 1)) ? '0 : wr_q + 1'b1;
			end
			if (pop) begin
				rd_q <= (rd_q == AW'(DEPTH - 1)) ? '0 : rd_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_q] <= push_data;
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n) !(push && full && !pop))
		else $error("queue pushed while full");
	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n) !(pop && empty))
		else $error("queue popped while empty");
endmodule

// ===== sv/lcoc_back.sv =====
// back end: reductions, extended euclid inverse, serial modular multiply, result register
module lcoc_back import lcoc_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  lcoc_job_t job,
	input  logic      job_valid,
	output logic      job_pop,
	lcoc_out_if.source result
);
	typedef enum logic [5:0] {
		S_IDLE = 6'b000001,
		S_RED  = 6'b000010,
		S_PREP = 6'b000100,
		S_INV  = 6'b001000,
		S_MUL  = 6'b010000,
		S_OUT  = 6'b100000
	} state_t;

	state_t       state_q;
	lcoc_job_t    job_q;
	logic [5:0]   cnt_q;
	logic         phase_q;
	logic         ok_q;
	logic [63:0]  rpp_q, rqr_q, rpr_q;
	logic [63:0]  r0_q, r1_q, t0_q, t1_q, d_q, ts_q;
	logic [63:0]  diff_q, acc_q;
	lcoc_result_t res_q;
	logic         out_valid_q;
	logic         out_load;

	function automatic logic [63:0] red_step(input logic [63:0] r, input logic b,
		input logic [63:0] m);
		logic [64:0] x;
		x = {r, b};
		return (x >= {1'b0, m}) ? 64'(x - {1'b0, m}) : x[63:0];
	endfunction

	assign job_pop      = (state_q == S_IDLE) && job_valid;
	assign out_load     = (state_q == S_OUT) && (!out_valid_q || result.ready);
	assign result.valid = out_valid_q;
	assign result.data  = res_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (result.ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (job_valid) begin
						state_q <= job.degen ? S_OUT : S_RED;
					end
				end
				S_RED: begin
					if (cnt_q == '0) begin
						state_q <= S_PREP;
					end
				end
				S_PREP: state_q <= S_INV;
				S_INV: begin
					if (r1_q == '0) begin
						state_q <= (r0_q == 64'd1) ? S_MUL : S_OUT;
					end
				end
				S_MUL: begin
					if (phase_q && cnt_q == '0) begin
						state_q <= S_OUT;
					end
				end
				S_OUT: begin
					if (out_load) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				job_q   <= job;
				cnt_q   <= 6'd63;
				phase_q <= 1'b0;
				ok_q    <= !job.degen;
				acc_q   <= '0;
				rpp_q   <= '0;
				rqr_q   <= '0;
				rpr_q   <= '0;
			end
			S_RED: begin
				rpp_q <= red_step(rpp_q, job_q.p_sq[cnt_q], job_q.modulus);
				rqr_q <= red_step(rqr_q, job_q.item.q_root[cnt_q], job_q.modulus);
				rpr_q <= red_step(rpr_q, job_q.item.p_root[cnt_q], job_q.modulus);
				cnt_q <= cnt_q - 1'b1;
			end
			S_PREP: begin
				diff_q <= sub_mod(rqr_q, rpr_q, job_q.modulus);
				r0_q   <= job_q.modulus;
				r1_q   <= rpp_q;
				t0_q   <= '0;
				t1_q   <= 64'd1;
				d_q    <= rpp_q;
				ts_q   <= 64'd1;
			end
			S_INV: begin
				if (r1_q == '0) begin
					ok_q    <= (r0_q == 64'd1);
					acc_q   <= '0;
					cnt_q   <= 6'd63;
					phase_q <= 1'b0;
				end else if (r0_q < r1_q) begin
					// quotient finished: rotate the remainder sequence
					r0_q <= r1_q;
					r1_q <= r0_q;
					t0_q <= t1_q;
					t1_q <= t0_q;
					d_q  <= r0_q;
					ts_q <= t0_q;
				end else if ({d_q, 1'b0} <= {1'b0, r0_q}) begin
					d_q  <= {d_q[62:0], 1'b0};
					ts_q <= add_mod(ts_q, ts_q, job_q.modulus);
				end else begin
					r0_q <= r0_q - d_q;
					t0_q <= sub_mod(t0_q, ts_q, job_q.modulus);
					d_q  <= r1_q;
					ts_q <= t1_q;
				end
			end
			S_MUL: begin
				phase_q <= !phase_q;
				if (!phase_q) begin
					acc_q <= add_mod(acc_q, acc_q, job_q.modulus);
				end else begin
					if (diff_q[cnt_q]) begin
						acc_q <= add_mod(acc_q, t0_q, job_q.modulus);
					end
					cnt_q <= cnt_q - 1'b1;
				end
			end
			S_OUT: begin
				if (out_load) begin
					res_q.hit      <= ok_q && (acc_q < 64'(job_q.item.lattice_limit));
					res_q.offset   <= ok_q ? acc_q : '0;
					res_q.out_p    <= job_q.item.prime_p;
					res_q.out_q    <= job_q.item.prime_q;
					res_q.out_root <= job_q.item.p_root;
					res_q.out_poly <= job_q.item.poly_index;
				end
			end
			default: ;
		endcase
	end

	a_mul_acc_reduced: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_MUL) |-> (acc_q < job_q.modulus && t0_q < job_q.modulus))
		else $error("multiply operands not reduced");
	a_inv_shift_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_INV && r1_q != '0 && r0_q >= r1_q) |-> (d_q <= r0_q && d_q >= r1_q))
		else $error("inverse shifted divisor out of range");
endmodule

// ===== sv/lattice_collision_offset_check.sv =====
// top level of the lattice collision offset check
// sequence: front register and queue, bit-serial reduction, a prep step, the euclid
//   inverse (one step per shift, subtract or swap plus one to finish), a bit-serial
//   multiply and the result register; a degenerate modulus skips straight to the result
// throughput: one item at a time in the back end; front and queue accept until the queue fills
// reset: arst_n clears all handshake and sequencer state asynchronously, queue empties
module lattice_collision_offset_check import lcoc_pkg::*; #(
	parameter int QDEPTH = QUEUE_DEPTH
) (
	input  logic        clk,
	input  logic        arst_n,
	lcoc_in_if.sink     item,
	lcoc_out_if.source  result
);
	// front to queue
	lcoc_job_t fq_job;
	logic      fq_valid;
	logic      q_full;
	// queue to back
	lcoc_job_t qb_job;
	logic      q_empty;
	logic      qb_pop;

	// front squares p and q and flags a modulus below 4
	lcoc_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.item     (item),
		.job      (fq_job),
		.job_valid(fq_valid),
		.job_ready(!q_full)
	);

	// decouples the front from the long back-end sequence
	lcoc_fifo #(.DEPTH(QDEPTH)) u_fifo (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (fq_valid && !q_full),
		.push_data(fq_job),
		.full     (q_full),
		.pop      (qb_pop),
		.pop_data (qb_job),
		.empty    (q_empty)
	);

	// back end produces one result transaction per job
	lcoc_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.job      (qb_job),
		.job_valid(!q_empty),
		.job_pop  (qb_pop),
		.result   (result)
	);
endmodule

// ===== sim/tb_lattice_collision_offset_check.sv =====
// testbench for the lattice collision offset check: random and directed items against a predictor
module tb_lattice_collision_offset_check;
	import lcoc_pkg::*;

	logic clk;
	logic arst_n;

	lcoc_in_if  in_ch();
	lcoc_out_if out_ch();

	lattice_collision_offset_check uut (
		.clk    (clk),
		.arst_n (arst_n),
		.item   (in_ch),
		.result (out_ch)
	);

	lcoc_item_t   pending_items[$];
	lcoc_result_t expected_offsets[$];

	int n_accepted;
	int n_checked;
	int n_hits;
	int n_errors;
	int send_idle_pct;
	int recv_idle_pct;
	int hold_cycles;
	bit hold_done;
	bit in_taken;

	// offset prediction: (q_root - p_root) * inverse(p*p) mod q*q
	function automatic lcoc_result_t predict_offset(input lcoc_item_t it);
		lcoc_result_t res;
		logic [63:0]  m, p2, qr, pr, diff;
		logic [63:0]  r0, r1, rn, t0, t1, tn, qq, prod;
		logic [127:0] wide;
		res.hit      = 1'b0;
		res.offset   = '0;
		res.out_p    = it.prime_p;
		res.out_q    = it.prime_q;
		res.out_root = it.p_root;
		res.out_poly = it.poly_index;
		if (it.prime_q >= 2) begin
			m    = 64'(it.prime_q) * 64'(it.prime_q);
			p2   = (64'(it.prime_p) * 64'(it.prime_p)) % m;
			qr   = it.q_root % m;
			pr   = it.p_root % m;
			diff = (qr >= pr) ? qr - pr : qr + (m - pr);
			// extended euclid, cofactor kept reduced mod m
			r0 = m;
			r1 = p2;
			t0 = 0;
			t1 = 1;
			while (r1 != 0) begin
				qq   = r0 / r1;
				rn   = r0 % r1;
				wide = 128'(t1) * 128'(qq);
				prod = 64'(wide % 128'(m));
				tn   = (t0 >= prod) ? t0 - prod : t0 + (m - prod);
				r0   = r1;
				r1   = rn;
				t0   = t1;
				t1   = tn;
			end
			if (r0 == 1) begin
				wide       = 128'(t0) * 128'(diff);
				res.offset = 64'(wide % 128'(m));
				res.hit    = res.offset < 64'(it.lattice_limit);
			end
		end
		return res;
	endfunction

	task automatic report_mismatch(input string field, input logic [63:0] got,
		input logic [63:0] want);
		$display("mismatch on %s: got %h, expected %h (result %0d)", field, got, want, n_checked);
		n_errors++;
	endtask

	task automatic queue_item(input logic [31:0] p, input logic [31:0] q, input logic [63:0] pr,
		input logic [63:0] qr, input logic [31:0] lim, input logic [7:0] poly);
		lcoc_item_t it;
		it.prime_p       = p;
		it.prime_q       = q;
		it.p_root        = pr;
		it.q_root        = qr;
		it.lattice_limit = lim;
		it.poly_index    = poly;
		pending_items.push_back(it);
	endtask

	function automatic logic [63:0] rand64();
		return {$urandom, $urandom};
	endfunction

	// clock
	initial begin
		clk = 0;
		forever #1 clk = ~clk;
	end

	// driver: new transaction offered at the falling edge once the previous one is taken
	always @(negedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_ch.valid <= 1'b0;
			in_ch.data  <= '0;
		end else if (!in_ch.valid || in_taken) begin
			if (pending_items.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
				in_ch.valid <= 1'b1;
				in_ch.data  <= pending_items.pop_front();
			end else begin
				in_ch.valid <= 1'b0;
			end
		end
	end

	// receiver ready, with random stalls and one long hold-off
	always @(negedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ch.ready <= 1'b0;
			hold_cycles  <= 0;
			hold_done    <= 1'b0;
		end else begin
			if (!hold_done && n_accepted >= 100) begin
				// long hold so the queue fills and the input backs up
				hold_cycles <= 3000;
				hold_done   <= 1'b1;
			end else if (hold_cycles > 0) begin
				hold_cycles <= hold_cycles - 1;
			end
			out_ch.ready <= (hold_cycles == 0) && ($urandom_range(99) >= recv_idle_pct);
		end
	end

	// monitor: predict on accepted items, check accepted results
	always @(posedge clk or negedge arst_n) begin
		lcoc_result_t want;
		lcoc_result_t got;
		if (!arst_n) begin
			in_taken <= 1'b0;
		end else begin
			in_taken <= in_ch.valid && in_ch.ready;
			if (in_ch.valid && in_ch.ready) begin
				expected_offsets.push_back(predict_offset(in_ch.data));
				n_accepted++;
			end
			if (out_ch.valid && out_ch.ready) begin
				got = out_ch.data;
				if (expected_offsets.size() == 0) begin
					$display("unexpected result transaction: %h", got);
					n_errors++;
				end else begin
					want = expected_offsets.pop_front();
					if (got.hit !== want.hit)
						report_mismatch("hit", 64'(got.hit), 64'(want.hit));
					if (got.offset !== want.offset)
						report_mismatch("offset", got.offset, want.offset);
					if (got.out_p !== want.out_p)
						report_mismatch("out_p", 64'(got.out_p), 64'(want.out_p));
					if (got.out_q !== want.out_q)
						report_mismatch("out_q", 64'(got.out_q), 64'(want.out_q));
					if (got.out_root !== want.out_root)
						report_mismatch("out_root", got.out_root, want.out_root);
					if (got.out_poly !== want.out_poly)
						report_mismatch("out_poly", 64'(got.out_poly), 64'(want.out_poly));
					n_hits += want.hit;
				end
				n_checked++;
			end
		end
	end

	// idle mix follows progress: sender-light first, then receiver-light, then none
	always @(posedge clk) begin
		if (n_accepted < 550) begin
			send_idle_pct <= 21;
			recv_idle_pct <= 48;
		end else if (n_accepted < 1100) begin
			send_idle_pct <= 48;
			recv_idle_pct <= 21;
		end else begin
			send_idle_pct <= 0;
			recv_idle_pct <= 0;
		end
	end

	// watchdog
	initial begin
		#40000000;
		$display("*** FAILED ***");
		$finish;
	end

	initial begin
		logic [31:0] p, q, lim;
		logic [63:0] m, pr, qr;
		n_accepted    = 0;
		n_checked     = 0;
		n_hits        = 0;
		n_errors      = 0;
		send_idle_pct = 21;
		recv_idle_pct = 48;
		arst_n        = 0;

		// directed: degenerate modulus, no inverse, extremes, unreduced roots
		queue_item(32'd7, 32'd0, 64'd5, 64'd9, 32'hffff_ffff, 8'd0);
		queue_item(32'd7, 32'd1, 64'd5, 64'd9, 32'hffff_ffff, 8'd255);
		queue_item(32'd13, 32'd13, 64'd20, 64'd100, 32'hffff_ffff, 8'd1);
		queue_item(32'd6, 32'd4, 64'd3, 64'd7, 32'hffff_ffff, 8'd2);
		queue_item(32'd0, 32'd11, 64'd0, 64'd50, 32'hffff_ffff, 8'd3);
		queue_item(32'd3, 32'd2, 64'd1, 64'd3, 32'hffff_ffff, 8'd4);
		queue_item(32'd3, 32'd2, 64'd1, 64'd3, 32'd0, 8'd5);
		queue_item(32'd5, 32'd7, 64'hffff_ffff_ffff_ffff, 64'hffff_ffff_ffff_ffff,
			32'd49, 8'd6);
		queue_item(32'd2, 32'hffff_fffb, 64'd0, 64'hffff_fff6_0000_0018, 32'hffff_ffff, 8'd7);
		queue_item(32'hffff_ffff, 32'hffff_fffb, 64'hffff_ffff_ffff_ffff, 64'd0,
			32'hffff_ffff, 8'd8);
		queue_item(32'hffff_ffff, 32'hffff_ffff, 64'd1, 64'd2, 32'd0, 8'd9);
		queue_item(32'hffff_fffb, 32'h7fff_ffff, 64'd12345, 64'hffff_ffff_ffff_fffe,
			32'h8000_0000, 8'd10);
		queue_item(32'd1, 32'd97, 64'd40, 64'd40, 32'd1, 8'd11);
		queue_item(32'd1, 32'd97, 64'd41, 64'd40, 32'hffff_ffff, 8'd12);
		queue_item(32'd5, 32'd3, 64'd9, 64'd8, 32'd5, 8'd128);

		// random: mostly small moduli so hits occur, some full width, some shared factors
		repeat (1635) begin
			case ($urandom_range(3))
				0: q = $urandom;
				1: q = $urandom_range(65535, 2);
				2: q = $urandom_range(255, 2);
				default: q = $urandom_range(8);
			endcase
			p = ($urandom_range(3) == 0) ? $urandom_range(1000) : $urandom;
			if ($urandom_range(15) == 0)
				p = q * $urandom_range(3, 1);
			m  = 64'(q) * 64'(q);
			pr = rand64();
			qr = rand64();
			if (m != 0 && $urandom_range(4) != 0)
				qr = qr % m;
			if (m != 0 && $urandom_range(1) == 0)
				lim = (m < 64'h1_0000_0000) ? $urandom_range(32'(m)) : $urandom;
			else
				lim = $urandom;
			queue_item(p, q, pr, qr, lim, 8'($urandom));
		end

		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n = 1;

		wait (pending_items.size() == 0 && !in_ch.valid && expected_offsets.size() == 0);
		repeat (2000) @(posedge clk);
		if (expected_offsets.size() != 0) begin
			$display("%0d expected results never arrived", expected_offsets.size());
			n_errors++;
		end
		$display("run covered %0d items and %0d checked results, %0d of them hits",
			n_accepted, n_checked, n_hits);
		$display("including degenerate moduli, non-invertible p squared and a long output stall");
		if (n_errors == 0) begin
			$display("*** PASSED ***");
		end else begin
			$display("%0d mismatches", n_errors);
			$display("*** FAILED ***");
		end
		$finish;
	end

endmodule
